// ----- rtl/mif_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mif_pkg
// Shared types and constants for the Fermat modular inverse block.
// ----------------------------------------------------------------------------
package mif_pkg;

  localparam int unsigned OPND_W = 32;  // operand width, two's complement
  localparam int unsigned RES_W  = 31;  // result field width
  localparam int unsigned CNT_W  = 6;   // step counter, holds OPND_W
  localparam int unsigned ADDR_W = 3;   // APB byte address
  localparam int unsigned DATA_W = 32;  // APB data

  // word index of the modulus register (paddr[2])
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_FIX,
    ST_CHECK,
    ST_NEXT,
    ST_MULT,
    ST_WB,
    ST_DONE
  } mif_state_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_STEP_RED,
    CMD_FIX,
    CMD_MUL_ACC,
    CMD_MUL_BASE,
    CMD_STEP_MUL,
    CMD_WB,
    CMD_EMIT
  } mif_cmd_e;

  typedef struct packed {
    logic cnt_last;   // step counter at its last step
    logic e_zero;     // exponent exhausted
    logic e_lsb;      // current exponent bit
    logic e_hi_zero;  // no exponent bits above the current one
    logic dst_acc;    // running product goes to the accumulator
    logic p_small;    // modulus below two
    logic out_free;   // output register can take a result
  } mif_status_t;

endpackage
`default_nettype wire

// ----- rtl/mif_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mif_req_if
// Request channel: one signed operand per request.
// ----------------------------------------------------------------------------
interface mif_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_value;

  modport source (output valid, output operand_value, input ready);
  modport sink   (input valid, input operand_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/mif_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mif_rsp_if
// Response channel: one inverse per request.
// ----------------------------------------------------------------------------
interface mif_rsp_if;
  logic        valid;
  logic        ready;
  logic [30:0] inverse_value;

  modport source (output valid, output inverse_value, input ready);
  modport sink   (input valid, input inverse_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/mif_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mif_ctrl
// Sequencer: reduction, then right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
module mif_ctrl
  import mif_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire mif_status_t status_i,
  output mif_cmd_e         cmd_o
);

  mif_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.p_small ? ST_DONE : ST_RED;
        end
      end
      ST_RED: begin
        if (status_i.cnt_last) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.e_zero) begin
          state_d = ST_DONE;
        end else if (status_i.e_lsb) begin
          state_d = ST_MULT;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: state_d = status_i.e_hi_zero ? ST_DONE : ST_MULT;
      ST_MULT: begin
        if (status_i.cnt_last) begin
          state_d = ST_WB;
        end
      end
      ST_WB:   state_d = status_i.dst_acc ? ST_NEXT : ST_CHECK;
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = CMD_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !status_i.p_small) begin
          cmd_o = CMD_LOAD;
        end
      end
      ST_RED: cmd_o = CMD_STEP_RED;
      ST_FIX: cmd_o = CMD_FIX;
      ST_CHECK: begin
        if (!status_i.e_zero && status_i.e_lsb) begin
          cmd_o = CMD_MUL_ACC;
        end
      end
      ST_NEXT: begin
        if (!status_i.e_hi_zero) begin
          cmd_o = CMD_MUL_BASE;
        end
      end
      ST_MULT: cmd_o = CMD_STEP_MUL;
      ST_WB:   cmd_o = CMD_WB;
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o = CMD_EMIT;
        end
      end
      default: cmd_o = CMD_NOP;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_RED || state_q == ST_DONE))
    else $error("accepted request did not start work");

  a_mult_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULT) |=> (state_q == ST_MULT || state_q == ST_WB))
    else $error("multiply left early");

  a_emit_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && status_i.out_free) |=> (state_q == ST_IDLE))
    else $error("finished result not released");
`endif

endmodule
`default_nettype wire

// ----- rtl/mif_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mif_datapath
// Shared bit-serial modular multiplier, exponent, accumulator, output reg.
// ----------------------------------------------------------------------------
module mif_datapath
  import mif_pkg::*;
#(
  parameter int unsigned MOD_BITS = 31
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mif_cmd_e            cmd_i,
  input  wire logic [MOD_BITS-1:0] modulus_i,
  input  wire logic [OPND_W-1:0]   operand_i,
  input  wire logic                out_ready_i,
  output mif_status_t              status_o,
  output logic                     out_valid_o,
  output logic [RES_W-1:0]         out_value_o
);

  localparam int unsigned MW = MOD_BITS;
  localparam int unsigned SW = MOD_BITS + 2;

  logic [MW-1:0]     acc_q, base_q, prod_q, mb_q, e_q, out_val_q;
  logic [OPND_W-1:0] opnd_q;
  logic              neg_q, dst_acc_q, out_valid_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              step_red, step_bit, p_small;
  logic [MW-1:0]     addend, prod_next, fix_val;
  logic [SW-1:0]     sum, p_ext, p2_ext;
  logic [OPND_W-1:0] mag;

  // one step: prod = (2*prod + bit*addend) mod p, sum stays below 3p
  always_comb begin
    step_red = (cmd_i == CMD_STEP_RED);
    step_bit = step_red ? opnd_q[OPND_W-1] : mb_q[MW-1];
    addend   = step_red ? MW'(1) : base_q;
    p_ext    = {2'b00, modulus_i};
    p2_ext   = {1'b0, modulus_i, 1'b0};
    sum      = {1'b0, prod_q, 1'b0} + (step_bit ? {2'b00, addend} : '0);
    if (sum >= p2_ext) begin
      prod_next = MW'(sum - p2_ext);
    end else if (sum >= p_ext) begin
      prod_next = MW'(sum - p_ext);
    end else begin
      prod_next = sum[MW-1:0];
    end
  end

  assign mag     = operand_i[OPND_W-1] ? (~operand_i + OPND_W'(1)) : operand_i;
  assign fix_val = (neg_q && prod_q != '0) ? (modulus_i - prod_q) : prod_q;
  assign p_small = (modulus_i < MW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_LOAD:                  cnt_q <= CNT_W'(OPND_W);
        CMD_MUL_ACC, CMD_MUL_BASE: cnt_q <= CNT_W'(MW);
        CMD_STEP_RED, CMD_STEP_MUL: cnt_q <= cnt_q - CNT_W'(1);
        default:                   cnt_q <= cnt_q;
      endcase
      if (cmd_i == CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        opnd_q <= mag;
        neg_q  <= operand_i[OPND_W-1];
        prod_q <= '0;
        e_q    <= modulus_i - MW'(2);
        acc_q  <= MW'(1);
      end
      CMD_STEP_RED: begin
        opnd_q <= opnd_q << 1;
        prod_q <= prod_next;
      end
      CMD_FIX: base_q <= fix_val;
      CMD_MUL_ACC: begin
        mb_q      <= acc_q;
        prod_q    <= '0;
        dst_acc_q <= 1'b1;
      end
      CMD_MUL_BASE: begin
        mb_q      <= base_q;
        prod_q    <= '0;
        dst_acc_q <= 1'b0;
        e_q       <= e_q >> 1;
      end
      CMD_STEP_MUL: begin
        mb_q   <= mb_q << 1;
        prod_q <= prod_next;
      end
      CMD_WB: begin
        if (dst_acc_q) begin
          acc_q <= prod_q;
        end else begin
          base_q <= prod_q;
        end
      end
      CMD_EMIT: out_val_q <= p_small ? '0 : acc_q;
      default: ;
    endcase
  end

  always_comb begin
    status_o.cnt_last  = (cnt_q == CNT_W'(1));
    status_o.e_zero    = (e_q == '0);
    status_o.e_lsb     = e_q[0];
    status_o.e_hi_zero = ((e_q >> 1) == '0);
    status_o.dst_acc   = dst_acc_q;
    status_o.p_small   = p_small;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = RES_W'(out_val_q);

`ifndef SYNTHESIS
  a_emit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_EMIT) |=> out_valid_q)
    else $error("emitted result not presented");
`endif

endmodule
`default_nettype wire

// ----- rtl/modular_inverse_fermat_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_fermat_top
// Modular inverse by Fermat's little theorem: operand^(p-2) mod p.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one signed 32-bit operand per request; rsp_o returns one
//   31-bit result per request, in order. Modulus p lives in the APB register
//   at word 0 (reset value 2); write it only while the block is idle.
//   The operand is first reduced into 0..p-1 by a bit-serial restoring pass,
//   then raised to p-2 by right-to-left square-and-multiply. Every modular
//   product runs through one shared bit-serial multiplier, one bit per step,
//   followed by a write-back. A p of 0 or 1 answers 0 without any multiply.
//   One request is worked at a time; req_i.ready is high only when idle.
//   The result sits in an output register, so a stalled receiver does not
//   stop the next request from being taken; the block waits only when a
//   second result is ready while the first is still unclaimed.
//   Reset clears the sequencer and the output valid and sets p back to 2.
// ----------------------------------------------------------------------------
module modular_inverse_fermat_top
  import mif_pkg::*;
#(
  parameter int unsigned MOD_BITS = 31
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  mif_req_if.sink                req_i,
  mif_rsp_if.source              rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [MOD_BITS-1:0] modulus_q;
  mif_cmd_e            cmd;
  mif_status_t         status;
  logic                cfg_wr;

  // register file: only the modulus, at word 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODULUS);
  assign prdata = (paddr[2] == REG_MODULUS) ? DATA_W'(modulus_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_BITS'(2);
    end else if (cfg_wr) begin
      modulus_q <= pwdata[MOD_BITS-1:0];
    end
  end

  mif_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mif_datapath #(
    .MOD_BITS (MOD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .modulus_i   (modulus_q),
    .operand_i   (req_i.operand_value),
    .out_ready_i (rsp_o.ready),
    .status_o    (status),
    .out_valid_o (rsp_o.valid),
    .out_value_o (rsp_o.inverse_value)
  );

endmodule
`default_nettype wire
